@@ rtl/core/rialu_pkg.sv @@
// Shared types, opcode and function codes, and status codes for the integer ALU.
// Used by every module of the block; depends on nothing.
package rialu_pkg;

   localparam int XLEN     = 32;
   localparam int REG_AW   = 5;
   localparam int NUM_REGS = 32;

   typedef logic [XLEN-1:0]   word_type;
   typedef logic [REG_AW-1:0] reg_index_type;

   localparam logic [1:0] ACT_EXEC    = 2'd0;
   localparam logic [1:0] ACT_PRELOAD = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_OP    = 2'd1;
   localparam logic [1:0] STATUS_UNIMPL_FN = 2'd2;

   localparam logic [5:0] OP_SPECIAL     = 6'h00;
   localparam logic [5:0] OP_ADDI        = 6'h08;
   localparam logic [5:0] OP_ADDI_NOTRAP = 6'h09;
   localparam logic [5:0] OP_SLTI        = 6'h0A;
   localparam logic [5:0] OP_SLTI_UNS    = 6'h0B;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_SLLV = 6'h04;
   localparam logic [5:0] FN_SRLV = 6'h06;
   localparam logic [5:0] FN_SRAV = 6'h07;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_XOR  = 6'h26;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   typedef struct packed {
      logic [1:0]    action;
      logic [5:0]    opcode;
      reg_index_type src_index;
      reg_index_type tgt_index;
      reg_index_type dst_index;
      logic [4:0]    shift_amount;
      logic [5:0]    function_code;
      logic [15:0]   immediate;
      word_type      preload_value;
   } req_item_type;

   typedef struct packed {
      logic          wrote;
      reg_index_type write_index;
      word_type      write_value;
      word_type      read_value;
      logic [1:0]    status;
   } exe_result_type;

   typedef struct packed {
      logic          en;
      reg_index_type addr;
      word_type      data;
   } rf_write_type;

endpackage

@@ rtl/core/rialu_regfile.sv @@
// Register file: 32 words, one write port and two registered read ports with write bypass.
// Uses rialu_pkg. Unwritten regs read 0; the user, not this block, keeps reg 0 unwritten.
module rialu_regfile import rialu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  reg_index_type rd_addr_a,
   input  reg_index_type rd_addr_b,
   input  rf_write_type  wr,
   output word_type      rd_data_a,
   output word_type      rd_data_b
);

   word_type              regs_ff [NUM_REGS];
   logic [NUM_REGS-1:0]   valid_ff;
   logic [NUM_REGS-1:0]   valid_in;
   word_type              rd_a_ff;
   word_type              rd_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.addr] <= wr.data;
      end
   end

   // A write in the same cycle is passed straight to the read register.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr.addr == rd_addr_a) begin
            rd_a_ff <= wr.data;
         end else if (valid_ff[rd_addr_a]) begin
            rd_a_ff <= regs_ff[rd_addr_a];
         end else begin
            rd_a_ff <= '0;
         end
         if (wr.en && wr.addr == rd_addr_b) begin
            rd_b_ff <= wr.data;
         end else if (valid_ff[rd_addr_b]) begin
            rd_b_ff <= regs_ff[rd_addr_b];
         end else begin
            rd_b_ff <= '0;
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/core/rialu_exec.sv @@
// Instruction decode and integer datapath: computes one result from a decoded item.
// Depends on rialu_pkg. Purely combinational.
module rialu_exec import rialu_pkg::*; (
   input  req_item_type   item,
   input  word_type       src_value,
   input  word_type       tgt_value,
   output exe_result_type result
);

   word_type simm;
   logic     lt_signed_reg;
   logic     lt_unsigned_reg;
   logic     lt_signed_imm;
   logic     lt_unsigned_imm;

   always_comb begin
      simm            = {{(XLEN-16){item.immediate[15]}}, item.immediate};
      lt_signed_reg   = $signed(src_value) < $signed(tgt_value);
      lt_unsigned_reg = src_value < tgt_value;
      lt_signed_imm   = $signed(src_value) < $signed(simm);
      lt_unsigned_imm = src_value < simm;
   end

   always_comb begin
      result        = '0;
      result.status = STATUS_OK;
      unique case (item.action)
         ACT_PRELOAD: begin
            result.wrote       = 1'b1;
            result.write_index = item.src_index;
            result.write_value = item.preload_value;
         end
         ACT_READ: begin
            result.read_value = src_value;
         end
         ACT_EXEC: begin
            if (item.opcode == OP_SPECIAL) begin
               result.wrote       = 1'b1;
               result.write_index = item.dst_index;
               unique case (item.function_code) inside
                  FN_SLL:  result.write_value = tgt_value << item.shift_amount;
                  FN_SRL:  result.write_value = tgt_value >> item.shift_amount;
                  FN_SRA:  result.write_value =
                              $unsigned($signed(tgt_value) >>> item.shift_amount);
                  FN_SLLV: result.write_value = tgt_value << src_value[4:0];
                  FN_SRLV: result.write_value = tgt_value >> src_value[4:0];
                  FN_SRAV: result.write_value =
                              $unsigned($signed(tgt_value) >>> src_value[4:0]);
                  FN_ADD, FN_ADDU: result.write_value = src_value + tgt_value;
                  FN_SUB, FN_SUBU: result.write_value = src_value - tgt_value;
                  FN_AND:  result.write_value = src_value & tgt_value;
                  FN_OR:   result.write_value = src_value | tgt_value;
                  FN_XOR:  result.write_value = src_value ^ tgt_value;
                  FN_SLT:  result.write_value = {{(XLEN-1){1'b0}}, lt_signed_reg};
                  FN_SLTU: result.write_value = {{(XLEN-1){1'b0}}, lt_unsigned_reg};
                  default: begin
                     result.wrote       = 1'b0;
                     result.write_index = '0;
                     result.status      = STATUS_UNIMPL_FN;
                  end
               endcase
            end else begin
               result.wrote       = 1'b1;
               result.write_index = item.tgt_index;
               unique case (item.opcode) inside
                  OP_ADDI, OP_ADDI_NOTRAP: result.write_value = src_value + simm;
                  OP_SLTI:     result.write_value = {{(XLEN-1){1'b0}}, lt_signed_imm};
                  OP_SLTI_UNS: result.write_value = {{(XLEN-1){1'b0}}, lt_unsigned_imm};
                  default: begin
                     result.wrote       = 1'b0;
                     result.write_index = '0;
                     result.status      = STATUS_BAD_OP;
                  end
               endcase
            end
         end
         default: begin
            result.status = STATUS_BAD_OP;
         end
      endcase
   end

endmodule

@@ rtl/core/risc_integer_alu_with_register_file.sv @@
// Top level of the integer ALU with register file: input stage, execute stage, result register.
// Depends on rialu_pkg, rialu_regfile and rialu_exec.
//
// The block accepts one transaction per clock while req_stall is low and returns one result
// per transaction, in order. In the accept cycle the two source registers are read into
// registered read ports; once the output register is free, the datapath computes the result,
// the destination register is written and the result is loaded into the output register. A
// register written by one transaction is seen by the very next one through a write bypass
// on the read ports, so back-to-back dependent instructions need no spacing. All registers
// read as zero after reset, and register zero always reads as zero. req_stall rises only
// when the execute stage holds a transaction and the output register is full and stalled.
module risc_integer_alu_with_register_file import rialu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_action,
   input  logic [5:0]    req_opcode,
   input  logic [4:0]    req_src_index,
   input  logic [4:0]    req_tgt_index,
   input  logic [4:0]    req_dst_index,
   input  logic [4:0]    req_shift_amount,
   input  logic [5:0]    req_function_code,
   input  logic [15:0]   req_immediate,
   input  logic [31:0]   req_preload_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_wrote,
   output logic [4:0]    rsp_write_index,
   output logic [31:0]   rsp_write_value,
   output logic [31:0]   rsp_read_value,
   output logic [1:0]    rsp_status
);

   logic           s1_valid_ff;
   logic           s1_valid_in;
   req_item_type   s1_item_ff;
   req_item_type   req_item;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   exe_result_type rsp_ff;
   logic           req_accept;
   logic           advance;
   word_type       src_value;
   word_type       tgt_value;
   exe_result_type exe_result;
   rf_write_type   rf_wr;

   assign req_item = '{
      action:        req_action,
      opcode:        req_opcode,
      src_index:     req_src_index,
      tgt_index:     req_tgt_index,
      dst_index:     req_dst_index,
      shift_amount:  req_shift_amount,
      function_code: req_function_code,
      immediate:     req_immediate,
      preload_value: req_preload_value
   };

   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      rf_wr.en   = advance && exe_result.wrote && (exe_result.write_index != '0);
      rf_wr.addr = exe_result.write_index;
      rf_wr.data = exe_result.write_value;
   end

   rialu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr_a (req_src_index),
      .rd_addr_b (req_tgt_index),
      .wr        (rf_wr),
      .rd_data_a (src_value),
      .rd_data_b (tgt_value)
   );

   rialu_exec u_exec (
      .item      (s1_item_ff),
      .src_value (src_value),
      .tgt_value (tgt_value),
      .result    (exe_result)
   );

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= exe_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wrote       = rsp_ff.wrote;
   assign rsp_write_index = rsp_ff.write_index;
   assign rsp_write_value = rsp_ff.write_value;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_status      = rsp_ff.status;

   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> rf_wr.addr != '0)
      else $error("register zero is being written");

   a_status_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |-> !rsp_ff.wrote)
      else $error("failed transaction reports a register write");

   a_no_write_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.wrote |-> rsp_ff.write_index == '0 && rsp_ff.write_value == '0)
      else $error("transaction without write carries write fields");

   a_free_output_advances: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("execute stage did not move into a free output register");

endmodule
